[rtl/core/msna_pkg.sv]
// Shared types and constants of the Morton stencil neighbor address block.
`timescale 1ns / 1ps
`default_nettype none

package msna_pkg;

  localparam int INDEX_W   = 18;
  localparam int SLOT_W    = 5;
  localparam int BITS_W    = 4;
  localparam int POS_W     = 5;
  localparam int EXTENT_W  = 7;
  localparam int MARGIN_W  = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 7;
  localparam int STENCIL_N = 27;
  localparam int CENTRE    = 13;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_I_BITS   = 3'd0,
    REG_J_BITS   = 3'd1,
    REG_K_BITS   = 3'd2,
    REG_I_EXTENT = 3'd3,
    REG_J_EXTENT = 3'd4,
    REG_K_EXTENT = 3'd5,
    REG_MARGIN   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [BITS_W-1:0]   i_bits;
    logic [BITS_W-1:0]   j_bits;
    logic [BITS_W-1:0]   k_bits;
    logic [EXTENT_W-1:0] i_extent;
    logic [EXTENT_W-1:0] j_extent;
    logic [EXTENT_W-1:0] k_extent;
    logic [MARGIN_W-1:0] margin;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] neighbor_index;
    logic [SLOT_W-1:0]  slot;
    logic               skipped;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/msna_if.sv]
// Valid/ready channel interfaces for cell indexes and neighbor results.
`timescale 1ns / 1ps
`default_nettype none

interface msna_in_if;
  logic               valid;
  logic               ready;
  msna_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface msna_out_if;
  logic                valid;
  logic                ready;
  msna_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/msna_cfg.sv]
// Configuration registers, effective axis bit counts and Morton bit positions.
`timescale 1ns / 1ps
`default_nettype none

module msna_cfg #(
  parameter int AXIS_BITS_MAX = 6
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [msna_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [msna_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output msna_pkg::cfg_t                           cfg,
  output logic [msna_pkg::POS_W-1:0]               pos_i [AXIS_BITS_MAX],
  output logic [msna_pkg::POS_W-1:0]               pos_j [AXIS_BITS_MAX],
  output logic [msna_pkg::POS_W-1:0]               pos_k [AXIS_BITS_MAX]
);

  localparam logic [msna_pkg::BITS_W-1:0] BMAX = msna_pkg::BITS_W'(AXIS_BITS_MAX);

  logic [2:0]                      i_bits_r, j_bits_r, k_bits_r;
  logic [msna_pkg::EXTENT_W-1:0]   i_extent_r, j_extent_r, k_extent_r;
  logic [msna_pkg::MARGIN_W-1:0]   margin_r;
  logic [msna_pkg::BITS_W-1:0]     ib, jb, kb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_bits_r   <= 3'd6;
      j_bits_r   <= 3'd6;
      k_bits_r   <= 3'd6;
      i_extent_r <= 7'd64;
      j_extent_r <= 7'd64;
      k_extent_r <= 7'd64;
      margin_r   <= '0;
    end else if (cfg_we) begin
      unique case (msna_pkg::cfg_reg_t'(cfg_addr))
        msna_pkg::REG_I_BITS:   i_bits_r   <= cfg_wdata[2:0];
        msna_pkg::REG_J_BITS:   j_bits_r   <= cfg_wdata[2:0];
        msna_pkg::REG_K_BITS:   k_bits_r   <= cfg_wdata[2:0];
        msna_pkg::REG_I_EXTENT: i_extent_r <= cfg_wdata;
        msna_pkg::REG_J_EXTENT: j_extent_r <= cfg_wdata;
        msna_pkg::REG_K_EXTENT: k_extent_r <= cfg_wdata;
        msna_pkg::REG_MARGIN:   margin_r   <= cfg_wdata[msna_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the maximum, then keep i >= j >= k
  always_comb begin
    logic [msna_pkg::BITS_W-1:0] a, b, c;
    a = {1'b0, i_bits_r};
    b = {1'b0, j_bits_r};
    c = {1'b0, k_bits_r};
    if (a > BMAX) a = BMAX;
    if (b > BMAX) b = BMAX;
    if (c > BMAX) c = BMAX;
    if (b > a) b = a;
    if (c > b) c = b;
    ib = a;
    jb = b;
    kb = c;
  end

  assign cfg.i_bits   = ib;
  assign cfg.j_bits   = jb;
  assign cfg.k_bits   = kb;
  assign cfg.i_extent = i_extent_r;
  assign cfg.j_extent = j_extent_r;
  assign cfg.k_extent = k_extent_r;
  assign cfg.margin   = margin_r;

  always_comb begin
    logic [msna_pkg::POS_W-1:0] base;
    logic                       kin, jin;
    base = '0;
    for (int s = 0; s < AXIS_BITS_MAX; s++) begin
      kin = (msna_pkg::BITS_W'(s) < kb);
      jin = (msna_pkg::BITS_W'(s) < jb);
      pos_k[s] = base;
      pos_j[s] = base + msna_pkg::POS_W'(kin);
      pos_i[s] = base + msna_pkg::POS_W'(kin) + msna_pkg::POS_W'(jin);
      base = base + msna_pkg::POS_W'(1) + msna_pkg::POS_W'(kin) + msna_pkg::POS_W'(jin);
    end
  end

endmodule

`default_nettype wire

[rtl/core/msna_front.sv]
// Front end: split a cell index, classify border cells, build the neighbor mask.
`timescale 1ns / 1ps
`default_nettype none

module msna_front #(
  parameter int AXIS_BITS_MAX = 6
) (
  input  wire msna_pkg::cfg_t              cfg,
  input  wire logic [msna_pkg::POS_W-1:0]  pos_i [AXIS_BITS_MAX],
  input  wire logic [msna_pkg::POS_W-1:0]  pos_j [AXIS_BITS_MAX],
  input  wire logic [msna_pkg::POS_W-1:0]  pos_k [AXIS_BITS_MAX],
  msna_in_if.sink                          in_ch,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output logic [AXIS_BITS_MAX-1:0]         ci,
  output logic [AXIS_BITS_MAX-1:0]         cj,
  output logic [AXIS_BITS_MAX-1:0]         ck,
  output logic                             skip,
  output logic [msna_pkg::STENCIL_N-1:0]   mask
);

  localparam int EW = ((AXIS_BITS_MAX > msna_pkg::EXTENT_W) ?
                       AXIS_BITS_MAX : msna_pkg::EXTENT_W) + 1;
  localparam logic [msna_pkg::POS_W-1:0] IDX_TOP = msna_pkg::POS_W'(msna_pkg::INDEX_W);

  logic [msna_pkg::INDEX_W-1:0] idx;
  logic [2:0] ei, ej, ek;
  logic       bi, bj, bk;

  assign idx = in_ch.data.cell_index;

  always_comb begin
    ci = '0;
    cj = '0;
    ck = '0;
    for (int s = 0; s < AXIS_BITS_MAX; s++) begin
      if (msna_pkg::BITS_W'(s) < cfg.k_bits && pos_k[s] < IDX_TOP) ck[s] = idx[pos_k[s]];
      if (msna_pkg::BITS_W'(s) < cfg.j_bits && pos_j[s] < IDX_TOP) cj[s] = idx[pos_j[s]];
      if (msna_pkg::BITS_W'(s) < cfg.i_bits && pos_i[s] < IDX_TOP) ci[s] = idx[pos_i[s]];
    end
  end

  function automatic logic border(input logic [AXIS_BITS_MAX-1:0] c,
                                  input logic [msna_pkg::EXTENT_W-1:0] ext,
                                  input logic [msna_pkg::MARGIN_W-1:0] mg);
    logic [EW-1:0] cw, ew, mw;
    cw = EW'(c);
    ew = EW'(ext);
    mw = EW'(mg);
    return (cw < mw) || (ew <= mw) || (cw >= ew - mw);
  endfunction

  // existence of the coordinate at offsets -1, 0, +1
  function automatic logic [2:0] exist3(input logic [AXIS_BITS_MAX-1:0] c,
                                        input logic [msna_pkg::EXTENT_W-1:0] ext,
                                        input logic [msna_pkg::BITS_W-1:0] nb);
    logic [EW-1:0] up;
    up = EW'(c) + EW'(1);
    return {(up < EW'(ext)) && (up < (EW'(1) << nb)), 1'b1, (c != '0)};
  endfunction

  assign bi = border(ci, cfg.i_extent, cfg.margin);
  assign bj = border(cj, cfg.j_extent, cfg.margin);
  assign bk = border(ck, cfg.k_extent, cfg.margin);
  assign skip = bi || bj || bk;

  assign ei = exist3(ci, cfg.i_extent, cfg.i_bits);
  assign ej = exist3(cj, cfg.j_extent, cfg.j_bits);
  assign ek = exist3(ck, cfg.k_extent, cfg.k_bits);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        for (int c = 0; c < 3; c++) begin
          mask[9*a + 3*b + c] = ei[a] && ej[b] && ek[c];
        end
      end
    end
    mask[msna_pkg::CENTRE] = 1'b0;
  end

  // drop interior cells without neighbors
  assign push_valid  = in_ch.valid && (skip || (mask != '0));
  assign in_ch.ready = push_ready;

endmodule

`default_nettype wire

[rtl/core/msna_fifo.sv]
// Short register queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module msna_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop)      count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

`default_nettype wire

[rtl/core/msna_back.sv]
// Back end: walk neighbor mask, one Morton address per cycle if ready.
`timescale 1ns / 1ps
`default_nettype none

module msna_back #(
  parameter int AXIS_BITS_MAX = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire msna_pkg::cfg_t              cfg,
  input  wire logic [msna_pkg::POS_W-1:0]  pos_i [AXIS_BITS_MAX],
  input  wire logic [msna_pkg::POS_W-1:0]  pos_j [AXIS_BITS_MAX],
  input  wire logic [msna_pkg::POS_W-1:0]  pos_k [AXIS_BITS_MAX],
  input  wire logic                        head_valid,
  input  wire logic [AXIS_BITS_MAX-1:0]    head_ci,
  input  wire logic [AXIS_BITS_MAX-1:0]    head_cj,
  input  wire logic [AXIS_BITS_MAX-1:0]    head_ck,
  input  wire logic                        head_skip,
  input  wire logic [msna_pkg::STENCIL_N-1:0] head_mask,
  output logic                             pop,
  msna_out_if.source                       out_ch
);

  localparam int CW = AXIS_BITS_MAX;
  localparam logic [msna_pkg::POS_W-1:0] IDX_TOP = msna_pkg::POS_W'(msna_pkg::INDEX_W);

  logic                             busy_r, skip_r, out_valid_r;
  logic [msna_pkg::STENCIL_N-1:0]   rem_r, sel, rem_left;
  logic [CW-1:0]                    ci_r, cj_r, ck_r, ni, nj, nk;
  logic [msna_pkg::SLOT_W-1:0]      slot_r;
  msna_pkg::out_item_t              out_data_r;
  logic [2:0]                       si, sj, sk;
  logic [msna_pkg::INDEX_W-1:0]     joined;
  logic                             adv, emit, finish, load;

  assign sel      = rem_r & (~rem_r + msna_pkg::STENCIL_N'(1));
  assign rem_left = rem_r & ~sel;
  assign adv      = !out_valid_r || out_ch.ready;
  assign emit     = busy_r && adv;
  assign finish   = emit && (skip_r || (rem_left == '0));
  assign load     = head_valid && (!busy_r || finish);
  assign pop      = load;

  always_comb begin
    si = '0;
    sj = '0;
    sk = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        for (int c = 0; c < 3; c++) begin
          si[a] = si[a] | sel[9*a + 3*b + c];
          sj[b] = sj[b] | sel[9*a + 3*b + c];
          sk[c] = sk[c] | sel[9*a + 3*b + c];
        end
      end
    end
  end

  function automatic logic [CW-1:0] step(input logic [CW-1:0] c, input logic [2:0] s);
    logic [CW-1:0] r;
    r = c;
    if (s[0]) r = c - CW'(1);
    else if (s[2]) r = c + CW'(1);
    return r;
  endfunction

  assign ni = step(ci_r, si);
  assign nj = step(cj_r, sj);
  assign nk = step(ck_r, sk);

  always_comb begin
    joined = '0;
    for (int s = 0; s < AXIS_BITS_MAX; s++) begin
      if (msna_pkg::BITS_W'(s) < cfg.k_bits && pos_k[s] < IDX_TOP) joined[pos_k[s]] = nk[s];
      if (msna_pkg::BITS_W'(s) < cfg.j_bits && pos_j[s] < IDX_TOP) joined[pos_j[s]] = nj[s];
      if (msna_pkg::BITS_W'(s) < cfg.i_bits && pos_i[s] < IDX_TOP) joined[pos_i[s]] = ni[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (load) begin
        busy_r <= 1'b1;
        slot_r <= '0;
      end else begin
        if (emit) slot_r <= slot_r + msna_pkg::SLOT_W'(1);
        if (finish) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (skip_r) begin
        out_data_r.neighbor_index <= '0;
        out_data_r.slot           <= '0;
        out_data_r.skipped        <= 1'b1;
        out_data_r.last           <= 1'b1;
      end else begin
        out_data_r.neighbor_index <= joined;
        out_data_r.slot           <= slot_r;
        out_data_r.skipped        <= 1'b0;
        out_data_r.last           <= (rem_left == '0);
      end
    end
    if (load) begin
      rem_r  <= head_mask;
      skip_r <= head_skip;
      ci_r   <= head_ci;
      cj_r   <= head_cj;
      ck_r   <= head_ck;
    end else if (emit) begin
      rem_r <= rem_left;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

`default_nettype wire

[rtl/core/morton_stencil_neighbor_addresses.sv]
// Top level of the 3D Morton 27-point stencil neighbor address generator.
// A cell index is accepted whenever the four-entry queue has room; the back
// end then emits one result per cycle from its output register while the
// output channel is ready: one result for a border cell, up to 26 for an
// interior cell, and none for an interior cell without neighbors, which is
// dropped before the queue. Sustained throughput is one result per clock
// while the output is ready, set by the back end walking the cell's
// neighbor mask. Registers take effect on the cycle after the write.
`timescale 1ns / 1ps
`default_nettype none

module morton_stencil_neighbor_addresses #(
  parameter int AXIS_BITS_MAX = 6
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [msna_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [msna_pkg::CFG_DATA_W-1:0] cfg_wdata,
  msna_in_if.sink                              in_ch,
  msna_out_if.source                           out_ch
);

  localparam int CW = AXIS_BITS_MAX;
  localparam int QW = 3*CW + 1 + msna_pkg::STENCIL_N;

  msna_pkg::cfg_t                  cfg;
  logic [msna_pkg::POS_W-1:0]      pos_i [AXIS_BITS_MAX];
  logic [msna_pkg::POS_W-1:0]      pos_j [AXIS_BITS_MAX];
  logic [msna_pkg::POS_W-1:0]      pos_k [AXIS_BITS_MAX];
  logic                            push_valid, full, pop, head_valid;
  logic [CW-1:0]                   f_ci, f_cj, f_ck, h_ci, h_cj, h_ck;
  logic                            f_skip, h_skip;
  logic [msna_pkg::STENCIL_N-1:0]  f_mask, h_mask;
  logic [QW-1:0]                   q_wdata, q_rdata;

  msna_cfg #(.AXIS_BITS_MAX(AXIS_BITS_MAX)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .pos_i     (pos_i),
    .pos_j     (pos_j),
    .pos_k     (pos_k)
  );

  msna_front #(.AXIS_BITS_MAX(AXIS_BITS_MAX)) u_front (
    .cfg        (cfg),
    .pos_i      (pos_i),
    .pos_j      (pos_j),
    .pos_k      (pos_k),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (!full),
    .ci         (f_ci),
    .cj         (f_cj),
    .ck         (f_ck),
    .skip       (f_skip),
    .mask       (f_mask)
  );

  assign q_wdata = {f_ci, f_cj, f_ck, f_skip, f_mask};

  msna_fifo #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .wdata     (q_wdata),
    .full      (full),
    .pop       (pop),
    .not_empty (head_valid),
    .rdata     (q_rdata)
  );

  assign {h_ci, h_cj, h_ck, h_skip, h_mask} = q_rdata;

  msna_back #(.AXIS_BITS_MAX(AXIS_BITS_MAX)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .pos_i      (pos_i),
    .pos_j      (pos_j),
    .pos_k      (pos_k),
    .head_valid (head_valid),
    .head_ci    (h_ci),
    .head_cj    (h_cj),
    .head_ck    (h_ck),
    .head_skip  (h_skip),
    .head_mask  (h_mask),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking regression bench for the Morton stencil neighbor address generator.
`timescale 1ns / 1ps

module testbench;

  localparam int AXIS_MAX    = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 40;
  localparam logic [msna_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  class stencil_scoreboard;
    logic [2:0] i_bits = 3'd6;
    logic [2:0] j_bits = 3'd6;
    logic [2:0] k_bits = 3'd6;
    logic [6:0] i_ext  = 7'd64;
    logic [6:0] j_ext  = 7'd64;
    logic [6:0] k_ext  = 7'd64;
    logic [5:0] margin = 6'd0;
    msna_pkg::out_item_t expected_neighbors[$];
    int         errors = 0;

    function void set_reg(logic [msna_pkg::CFG_ADDR_W-1:0] addr,
                          logic [msna_pkg::CFG_DATA_W-1:0] value);
      case (addr)
        msna_pkg::REG_I_BITS:   i_bits = value[2:0];
        msna_pkg::REG_J_BITS:   j_bits = value[2:0];
        msna_pkg::REG_K_BITS:   k_bits = value[2:0];
        msna_pkg::REG_I_EXTENT: i_ext  = value[6:0];
        msna_pkg::REG_J_EXTENT: j_ext  = value[6:0];
        msna_pkg::REG_K_EXTENT: k_ext  = value[6:0];
        msna_pkg::REG_MARGIN:   margin = value[5:0];
        default: ;
      endcase
    endfunction

    function void layout(output int ib, output int jb, output int kb);
      ib = (i_bits > AXIS_MAX) ? AXIS_MAX : int'(i_bits);
      jb = (j_bits > AXIS_MAX) ? AXIS_MAX : int'(j_bits);
      kb = (k_bits > AXIS_MAX) ? AXIS_MAX : int'(k_bits);
      if (jb > ib) jb = ib;
      if (kb > jb) kb = jb;
    endfunction

    function logic [msna_pkg::INDEX_W-1:0] join_coords(int ci, int cj, int ck);
      int ib, jb, kb, pos, s;
      logic [31:0] r;
      layout(ib, jb, kb);
      pos = 0;
      r = '0;
      for (s = 0; s < ib; s++) begin
        if (s < kb) begin
          r[pos] = ck[s];
          pos++;
        end
        if (s < jb) begin
          r[pos] = cj[s];
          pos++;
        end
        r[pos] = ci[s];
        pos++;
      end
      return r[msna_pkg::INDEX_W-1:0];
    endfunction

    function void split_index(logic [msna_pkg::INDEX_W-1:0] idx, output int ci,
                              output int cj, output int ck);
      int ib, jb, kb, pos, s;
      layout(ib, jb, kb);
      pos = 0;
      ci = 0;
      cj = 0;
      ck = 0;
      for (s = 0; s < ib; s++) begin
        if (s < kb) begin
          ck[s] = idx[pos];
          pos++;
        end
        if (s < jb) begin
          cj[s] = idx[pos];
          pos++;
        end
        ci[s] = idx[pos];
        pos++;
      end
    endfunction

    function bit in_border(int c, int ext);
      int m;
      m = int'(margin);
      return (c < m) || (ext <= m) || (c >= ext - m);
    endfunction

    function bit on_axis(int c, int ext, int nb);
      return (c >= 0) && (c < ext) && (c <= (1 << nb) - 1);
    endfunction

    function void note_cell(logic [msna_pkg::INDEX_W-1:0] idx);
      int ib, jb, kb, ci, cj, ck, n, di, dj, dk;
      msna_pkg::out_item_t r;
      layout(ib, jb, kb);
      split_index(idx, ci, cj, ck);
      r = '0;
      if (in_border(ci, int'(i_ext)) || in_border(cj, int'(j_ext)) ||
          in_border(ck, int'(k_ext))) begin
        r.skipped = 1'b1;
        r.last    = 1'b1;
        expected_neighbors.push_back(r);
        return;
      end
      n = 0;
      for (di = -1; di <= 1; di++) begin
        if (!on_axis(ci + di, int'(i_ext), ib)) continue;
        for (dj = -1; dj <= 1; dj++) begin
          if (!on_axis(cj + dj, int'(j_ext), jb)) continue;
          for (dk = -1; dk <= 1; dk++) begin
            if (!on_axis(ck + dk, int'(k_ext), kb)) continue;
            if (di == 0 && dj == 0 && dk == 0) continue;
            r.neighbor_index = join_coords(ci + di, cj + dj, ck + dk);
            r.slot           = n[msna_pkg::SLOT_W-1:0];
            r.skipped        = 1'b0;
            r.last           = 1'b0;
            expected_neighbors.push_back(r);
            n++;
          end
        end
      end
      if (n > 0) begin
        r = expected_neighbors.pop_back();
        r.last = 1'b1;
        expected_neighbors.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(msna_pkg::out_item_t got);
      msna_pkg::out_item_t want;
      if (expected_neighbors.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      want = expected_neighbors.pop_front();
      compare_field("neighbor_index", want.neighbor_index, got.neighbor_index);
      compare_field("slot", want.slot, got.slot);
      compare_field("skipped", want.skipped, got.skipped);
      compare_field("last", want.last, got.last);
    endfunction

    function int pick_coord(int ext, int nb, int m);
      int lim, v;
      lim = (ext < (1 << nb)) ? ext - 1 : (1 << nb) - 1;
      if (lim < 0) lim = 0;
      case ($urandom_range(0, 4))
        0: v = m;
        1: v = ext - 1 - m;
        2: v = $urandom_range(0, (1 << nb) - 1);
        default: v = $urandom_range(0, lim);
      endcase
      if (v < 0) v = 0;
      if (v > (1 << nb) - 1) v = (1 << nb) - 1;
      return v;
    endfunction

    function logic [msna_pkg::INDEX_W-1:0] random_cell();
      int ib, jb, kb;
      logic [msna_pkg::INDEX_W-1:0] idx;
      logic [31:0] upper;
      if ($urandom_range(0, 3) == 0) return msna_pkg::INDEX_W'($urandom());
      layout(ib, jb, kb);
      idx = join_coords(pick_coord(int'(i_ext), ib, int'(margin)),
                        pick_coord(int'(j_ext), jb, int'(margin)),
                        pick_coord(int'(k_ext), kb, int'(margin)));
      upper = $urandom() << (ib + jb + kb);
      if ($urandom_range(0, 1) == 1) idx = idx | upper[msna_pkg::INDEX_W-1:0];
      return idx;
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [msna_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [msna_pkg::CFG_DATA_W-1:0] cfg_wdata;
  idle_mode_t                      idle_mode = IDLE_NONE;
  int                              cycles = 0;
  stencil_scoreboard               sb = new();

  msna_in_if  in_ch();
  msna_out_if out_ch();

  morton_stencil_neighbor_addresses #(
    .AXIS_BITS_MAX(AXIS_MAX)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("morton_stencil_neighbor_addresses regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_cell(in_ch.data.cell_index);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_ch.ready <= ($urandom_range(0, 99) >= 55);
      IDLE_BOTH: out_ch.ready <= ($urandom_range(0, 99) >= 32);
      default:   out_ch.ready <= 1'b1;
    endcase
  end

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 55;
      IDLE_BOTH: return $urandom_range(0, 99) < 32;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic send_cell(logic [msna_pkg::INDEX_W-1:0] idx);
    @(negedge clk);
    while (sender_gap()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.data.cell_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_neighbors.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic program_reg(logic [msna_pkg::CFG_ADDR_W-1:0] addr,
                             logic [msna_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(addr, value);
  endtask

  task automatic run_phase(int ib, int jb, int kb, int ie, int je, int ke, int mg,
                           int count, idle_mode_t mode);
    wait_idle();
    program_reg(msna_pkg::REG_I_BITS, msna_pkg::CFG_DATA_W'(ib));
    program_reg(msna_pkg::REG_J_BITS, msna_pkg::CFG_DATA_W'(jb));
    program_reg(msna_pkg::REG_K_BITS, msna_pkg::CFG_DATA_W'(kb));
    program_reg(msna_pkg::REG_I_EXTENT, msna_pkg::CFG_DATA_W'(ie));
    program_reg(msna_pkg::REG_J_EXTENT, msna_pkg::CFG_DATA_W'(je));
    program_reg(msna_pkg::REG_K_EXTENT, msna_pkg::CFG_DATA_W'(ke));
    program_reg(msna_pkg::REG_MARGIN, msna_pkg::CFG_DATA_W'(mg));
    @(negedge clk);
    cfg_we    <= 1'b0;
    idle_mode = mode;
    repeat (count) send_cell(sb.random_cell());
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corners, faces and the full interior stencil at the reset layout
    send_cell(18'h00000);
    send_cell(18'h3FFFF);
    send_cell(sb.join_coords(32, 32, 32));
    send_cell(sb.join_coords(0, 32, 32));
    send_cell(sb.join_coords(63, 0, 31));
    send_cell(sb.join_coords(31, 63, 0));
    send_cell(sb.join_coords(1, 62, 1));
    send_cell(18'h2AAAA);
    send_cell(18'h15555);

    wait_idle();
    program_reg(REG_UNUSED, 7'h7F);

    run_phase(0, 0, 0, 1, 1, 1, 0, 3, IDLE_NONE);
    run_phase(6, 6, 6, 0, 0, 0, 0, 3, IDLE_SEND);
    run_phase(7, 7, 7, 127, 127, 127, 0, 4, IDLE_RECV);
    run_phase(3, 5, 6, 8, 8, 8, 2, 4, IDLE_BOTH);
    run_phase(6, 6, 6, 64, 64, 64, 63, 2, IDLE_NONE);

    run_phase(2, 2, 2, 4, 4, 4, 1, 13, IDLE_NONE);
    run_phase(6, 4, 2, 64, 16, 4, 1, 13, IDLE_SEND);
    run_phase(1, 1, 1, 2, 2, 2, 0, 13, IDLE_RECV);
    run_phase(6, 6, 6, 40, 50, 60, 3, 15, IDLE_BOTH);
    run_phase(5, 3, 3, 32, 8, 7, 0, 13, IDLE_NONE);
    run_phase(6, 6, 6, 64, 64, 64, 31, 13, IDLE_SEND);
    run_phase(4, 4, 4, 16, 16, 16, 0, 13, IDLE_RECV);
    run_phase(6, 6, 5, 64, 33, 32, 32, 13, IDLE_BOTH);

    wait_idle();
    if (sb.errors == 0) begin
      $display("morton_stencil_neighbor_addresses regression: pass");
    end else begin
      $display("morton_stencil_neighbor_addresses regression: fail");
    end
    $finish;
  end

endmodule
